[design/mlpq_pkg.sv]
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared constants, status codes and interface types for the multi-level
// priority FIFO: level count, ring depth, word width and derived widths.
// ----------------------------------------------------------------------------
package mlpq_pkg;

  localparam int LEVELS     = 8;
  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;

  // Fixed port widths
  localparam int PORT_DW = 32;
  localparam int PRI_W   = 3;
  localparam int STAT_W  = 2;

  // Derived widths
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = $clog2(2 * DEPTH);
  localparam int WORDS  = LEVELS * DEPTH;
  localparam int ADDR_W = $clog2(WORDS);

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  // Commands from the controller to the level bookkeeping
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [PRI_W-1:0] push_pri;
  } mlpq_cmd_t;

  // Status from the level bookkeeping to the controller
  typedef struct packed {
    logic              push_ok;
    logic [ADDR_W-1:0] tail_addr;
    logic              pop_ok;
    logic [LVL_W-1:0]  pop_level;
    logic [ADDR_W-1:0] head_addr;
  } mlpq_info_t;

endpackage

[design/multi_level_priority_fifo.sv]
// Results: an insert or empty-queue remove loads the output register at accept;
// a successful remove first enters S_READ for the registered store read, then
// loads it. One insert per cycle while out_ready keeps the result drained; a
// remove holds off the input while the entry store read completes.
// Reset: synchronous active-low rst_n empties every level and the output
// register; store contents stay undefined until written.
// ----------------------------------------------------------------------------
// multi_level_priority_fifo
// Priority queue of per-level circular FIFOs sharing one entry store.
// Inserts append to a level's ring; removes pop the highest non-empty level.
// ----------------------------------------------------------------------------
module multi_level_priority_fifo
  import mlpq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic signed [PORT_DW-1:0] in_data_in,
  input  logic        [PRI_W-1:0]   in_priority_req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic        [STAT_W-1:0]  out_status,
  output logic signed [PORT_DW-1:0] out_data_out,
  output logic        [PRI_W-1:0]   out_level_out
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                  state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]     status_r, status_nxt;
  logic [PORT_DW-1:0]    data_r, data_nxt;
  logic [PRI_W-1:0]      level_r, level_nxt;
  logic [LVL_W-1:0]      pop_lvl_r, pop_lvl_nxt;

  logic                  accept;
  logic                  is_insert;
  mlpq_cmd_t             cmd;
  mlpq_info_t            info;
  logic [DATA_WIDTH-1:0] rd_data;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign is_insert = (in_action == ACT_INSERT);

  // Issue level updates for the accepted transaction
  assign cmd.push     = accept && is_insert && info.push_ok;
  assign cmd.pop      = accept && !is_insert && info.pop_ok;
  assign cmd.push_pri = in_priority_req;

  mlpq_levels u_levels (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .info  (info)
  );

  mlpq_ram u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (info.tail_addr),
    .wr_data (DATA_WIDTH'(in_data_in)),
    .rd_en   (cmd.pop),
    .rd_addr (info.head_addr),
    .rd_data (rd_data)
  );

  // Sequence transactions and load the output register
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    level_nxt     = level_r;
    pop_lvl_nxt   = pop_lvl_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_insert) begin
            out_valid_nxt = 1'b1;
            status_nxt    = info.push_ok ? ST_INSERTED : ST_FULL;
            data_nxt      = '0;
            level_nxt     = '0;
          end else if (info.pop_ok) begin
            pop_lvl_nxt = info.pop_level;
            state_nxt   = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_EMPTY;
            data_nxt      = '0;
            level_nxt     = '0;
          end
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_REMOVED;
        data_nxt      = PORT_DW'(rd_data);
        level_nxt     = PRI_W'(pop_lvl_r);
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    data_r    <= data_nxt;
    level_r   <= level_nxt;
    pop_lvl_r <= pop_lvl_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_data_out  = data_r;
  assign out_level_out = level_r;

  // Hold input while the store read is in flight
  a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !in_ready)
    else $error("input accepted during store read");

  // Read cycle always delivers a removed word
  a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (out_valid_r && (status_r == ST_REMOVED)))
    else $error("store read did not produce a removed result");

  // Non-remove results carry zero word and level
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_REMOVED)) |-> ((data_r == '0) && (level_r == '0)))
    else $error("non-remove result has nonzero payload");

  // Successful remove enters the read state
  a_pop_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (state_r == S_READ))
    else $error("remove did not start a store read");

endmodule

[design/mlpq_ram.sv]
// ----------------------------------------------------------------------------
// mlpq_ram
// Shared entry store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module mlpq_ram
  import mlpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/mlpq_levels.sv]
// ----------------------------------------------------------------------------
// mlpq_levels
// Per-level head pointers and occupancy counts, tail address computation and
// the priority encoder that picks the highest non-empty level.
// ----------------------------------------------------------------------------
module mlpq_levels
  import mlpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mlpq_cmd_t  cmd,
  output mlpq_info_t info
);

  logic [PTR_W-1:0] head_r [LEVELS];
  logic [CNT_W-1:0] cnt_r  [LEVELS];

  logic             pri_in_range;
  logic [LVL_W-1:0] push_lvl;
  logic [PTR_W-1:0] push_head;
  logic [CNT_W-1:0] push_cnt;
  logic [SUM_W-1:0] tail_sum;
  logic [PTR_W-1:0] tail_ptr;
  logic             found;
  logic [LVL_W-1:0] top_lvl;
  logic [PTR_W-1:0] top_head;
  logic [PTR_W-1:0] top_head_inc;

  // Look up the requested level for an insert
  assign pri_in_range = 32'(cmd.push_pri) < 32'(LEVELS);
  assign push_lvl     = LVL_W'(cmd.push_pri);
  assign push_head    = head_r[push_lvl];
  assign push_cnt     = cnt_r[push_lvl];

  // Wrap head plus count into the ring
  always_comb begin
    tail_sum = SUM_W'(push_head) + SUM_W'(push_cnt);
    if (tail_sum >= SUM_W'(DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(DEPTH);
    end
    tail_ptr = PTR_W'(tail_sum);
  end

  // Find the highest-numbered non-empty level
  always_comb begin
    found   = 1'b0;
    top_lvl = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        found   = 1'b1;
        top_lvl = LVL_W'(i);
      end
    end
  end

  assign top_head     = head_r[top_lvl];
  assign top_head_inc = (32'(top_head) == DEPTH - 1) ? '0 : top_head + PTR_W'(1);

  assign info.push_ok   = pri_in_range && (push_cnt < CNT_W'(DEPTH));
  assign info.tail_addr = ADDR_W'(push_lvl) * ADDR_W'(DEPTH) + ADDR_W'(tail_ptr);
  assign info.pop_ok    = found;
  assign info.pop_level = top_lvl;
  assign info.head_addr = ADDR_W'(top_lvl) * ADDR_W'(DEPTH) + ADDR_W'(top_head);

  // Grow the count on push; advance head and shrink the count on pop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (cmd.push) begin
        cnt_r[push_lvl] <= push_cnt + CNT_W'(1);
      end
      if (cmd.pop) begin
        head_r[top_lvl] <= top_head_inc;
        cnt_r[top_lvl]  <= cnt_r[top_lvl] - CNT_W'(1);
      end
    end
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-level priority FIFO. A behavioral copy of
// the per-level rings predicts every result; directed tests cover the empty
// queue, data extremes, level ordering and overflow; random phases push fill,
// drain and ring wrap-around with random idling on both channels, bar the last.
// ----------------------------------------------------------------------------
module tb_top
  import mlpq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 4;

  typedef struct packed {
    logic        [STAT_W-1:0]  status;
    logic signed [PORT_DW-1:0] data;
    logic        [PRI_W-1:0]   level;
  } outcome_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_action = ACT_INSERT;
  logic signed [PORT_DW-1:0] in_data_in = '0;
  logic        [PRI_W-1:0]   in_priority_req = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic        [STAT_W-1:0]  out_status;
  logic signed [PORT_DW-1:0] out_data_out;
  logic        [PRI_W-1:0]   out_level_out;

  // Shadow copy of the queue state
  logic [DATA_WIDTH-1:0] ring_word [LEVELS][DEPTH];
  int                    ring_head [LEVELS];
  int                    ring_count[LEVELS];

  outcome_t outcome_q[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  n_inserted  = 0;
  int  n_dropped   = 0;
  int  n_removed   = 0;
  int  n_empty     = 0;
  bit  idle_on     = 1'b1;
  bit  stall_on    = 1'b1;
  int  stall_left  = 0;

  multi_level_priority_fifo u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_data_in      (in_data_in),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_level_out   (out_level_out)
  );

  // Clock: 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, outcome_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Apply one operation to the shadow queue and return its outcome
  function automatic outcome_t apply_queue_op(logic act, logic signed [PORT_DW-1:0] word,
                                              logic [PRI_W-1:0] pri);
    outcome_t res;
    int       lvl;
    int       slot;
    bit       found;
    res   = '{status: ST_EMPTY, data: '0, level: '0};
    found = 1'b0;
    if (act == ACT_INSERT) begin
      if (int'(pri) >= LEVELS || ring_count[pri] >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        slot = (ring_head[pri] + ring_count[pri]) % DEPTH;
        ring_word[pri][slot] = DATA_WIDTH'($unsigned(word));
        ring_count[pri]++;
        res.status = ST_INSERTED;
      end
    end else begin
      // Highest non-empty level wins; its head stays put once emptied
      for (lvl = LEVELS - 1; lvl >= 0; lvl--) begin
        if (!found && ring_count[lvl] != 0) begin
          found      = 1'b1;
          res.status = ST_REMOVED;
          res.data   = PORT_DW'(ring_word[lvl][ring_head[lvl]]);
          res.level  = PRI_W'(lvl);
          ring_head[lvl] = (ring_head[lvl] + 1) % DEPTH;
          ring_count[lvl]--;
        end
      end
    end
    return res;
  endfunction

  // Result side back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(1, 17) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      case (out_status)
        ST_INSERTED: n_inserted++;
        ST_FULL:     n_dropped++;
        ST_REMOVED:  n_removed++;
        default:     n_empty++;
      endcase
      if (outcome_q.size() == 0) begin
        $error("result with no prediction: status %0d data %0h level %0d",
               out_status, out_data_out, out_level_out);
        error_count++;
      end else begin
        want = outcome_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          error_count++;
        end
        if (out_data_out !== want.data) begin
          $error("data_out: expected %0h, actual %0h", want.data, out_data_out);
          error_count++;
        end
        if (out_level_out !== want.level) begin
          $error("level_out: expected %0d, actual %0d", want.level, out_level_out);
          error_count++;
        end
      end
    end
  end

  // Send one input transaction, with an optional idle burst first
  task automatic send_op(logic act, logic signed [PORT_DW-1:0] word, logic [PRI_W-1:0] pri);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_action       = act;
    in_data_in      = word;
    in_priority_req = pri;
    do @(posedge clk); while (!in_ready);
    outcome_q.push_back(apply_queue_op(act, word, pri));
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [PORT_DW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(PORT_DW-1){1'b0}}};
      1:       return {1'b0, {(PORT_DW-1){1'b1}}};
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Random mix: insert share in percent over a window of levels
  task automatic run_random(int count, int insert_pct, int lo_pri, int hi_pri);
    logic act;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
      send_op(act, pick_word(), PRI_W'($urandom_range(lo_pri, hi_pri)));
    end
  endtask

  task automatic test_empty_queue();
    send_op(ACT_REMOVE, $urandom, PRI_W'($urandom));
  endtask

  // One word per level with data extremes, then the top two come out first
  task automatic test_level_order();
    send_op(ACT_INSERT, {1'b1, {(PORT_DW-1){1'b0}}}, 3'd0);
    send_op(ACT_INSERT, {1'b0, {(PORT_DW-1){1'b1}}}, 3'd7);
    send_op(ACT_INSERT, '1, 3'd1);
    send_op(ACT_INSERT, '0, 3'd6);
    send_op(ACT_INSERT, 32'sd1, 3'd2);
    send_op(ACT_INSERT, 32'hAAAA_AAAA, 3'd5);
    send_op(ACT_INSERT, 32'h5555_5555, 3'd3);
    send_op(ACT_INSERT, $urandom, 3'd4);
    send_op(ACT_REMOVE, $urandom, PRI_W'($urandom));
    send_op(ACT_REMOVE, $urandom, PRI_W'($urandom));
  endtask

  // Fill one level to capacity, overflow it, then pop part of it in order
  task automatic test_level_overflow();
    for (int i = 1; i < DEPTH; i++) send_op(ACT_INSERT, $urandom, 3'd5);
    send_op(ACT_INSERT, $urandom, 3'd5);
    for (int i = 0; i < 4; i++) send_op(ACT_REMOVE, $urandom, PRI_W'($urandom));
  endtask

  task automatic test_random_fill();
    run_random(200, 85, 2, 3);
  endtask

  task automatic test_random_mixed();
    run_random(400, 50, 0, LEVELS - 1);
  endtask

  task automatic test_random_drain();
    run_random(200, 25, 0, LEVELS - 1);
  endtask

  // Hammer a single level so its ring wraps many times, then mix all levels
  task automatic test_ring_wrap();
    int lvl;
    lvl = $urandom_range(0, LEVELS - 1);
    run_random(250, 55, lvl, lvl);
    run_random(300, 50, 0, LEVELS - 1);
  endtask

  // Full-rate traffic with no idling on either side
  task automatic test_back_to_back();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    run_random(300, 50, 0, LEVELS - 1);
  endtask

  initial begin
    for (int l = 0; l < LEVELS; l++) begin
      ring_head[l]  = 0;
      ring_count[l] = 0;
    end
    // Hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_queue();
    test_level_order();
    test_level_overflow();
    wait_drained();
    test_random_fill();
    test_random_mixed();
    wait_drained();
    test_random_drain();
    test_ring_wrap();
    wait_drained();
    test_back_to_back();

    // Drain, then allow the longest latency to pass
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d transactions in %0d cycles", n_inserted + n_dropped + n_removed + n_empty,
             cycle_count);
    $display("  inserts %0d, dropped on full level %0d, removes %0d, removes on empty %0d",
             n_inserted, n_dropped, n_removed, n_empty);
    if (error_count == 0 && outcome_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
